/* src/b2ad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b2ad_pkg;

    localparam int BIN_W           = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int NUM_CHARS       = 11;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DAB_STAGES      = BIN_W / STEPS_PER_STAGE;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [2:0] FMT_HEX8  = 3'd0;
    localparam logic [2:0] FMT_DEC8  = 3'd1;
    localparam logic [2:0] FMT_DEC16 = 3'd2;
    localparam logic [2:0] FMT_DEC32 = 3'd3;

    localparam logic [3:0] LEN_HEX8   = 4'd2;
    localparam logic [3:0] LEN_DEC8   = 4'd3;
    localparam logic [3:0] LEN_DEC16  = 4'd5;
    localparam logic [3:0] LEN_DEC32  = 4'd10;
    localparam logic [3:0] LEN_SIGNED = 4'd11;

    typedef enum logic [2:0] {
        MODE_HEX8,
        MODE_DEC8,
        MODE_DEC16,
        MODE_DEC32,
        MODE_SIGNED
    } t_mode;

    typedef logic [7:0] t_char;

    // one shift-add-3 step: correct every digit, then shift in the next bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < DIGITS; k++) begin
            if (bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    function automatic t_char hex_char(input logic [3:0] nib);
        if (nib <= 4'd9) begin
            return CH_ZERO + {4'd0, nib};
        end
        return CH_UPPER + {4'd0, nib - 4'd10};
    endfunction

    function automatic t_char dec_char(input logic [3:0] dig);
        return CH_ZERO + {4'd0, dig};
    endfunction

endpackage

`default_nettype wire

/* src/binary_to_ascii_decimal_hex_top.sv */
// an accepted word passes through the pipeline to its o_strobe pulse
// (one entry stage, eight shift-add-3 stages of four bits each, one formatting stage)
// throughput: one word per cycle; o_busy stays low since the receiver cannot stall
// reset: synchronous, active low, clears the stage valid bits and the strobe only
`timescale 1ns / 1ps
`default_nettype none

module binary_to_ascii_decimal_hex_top
    import b2ad_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_value,
    input  wire logic [2:0]  i_format,
    output logic             o_strobe,
    output logic [7:0]       o_text_0,
    output logic [7:0]       o_text_1,
    output logic [7:0]       o_text_2,
    output logic [7:0]       o_text_3,
    output logic [7:0]       o_text_4,
    output logic [7:0]       o_text_5,
    output logic [7:0]       o_text_6,
    output logic [7:0]       o_text_7,
    output logic [7:0]       o_text_8,
    output logic [7:0]       o_text_9,
    output logic [7:0]       o_text_10,
    output logic [3:0]       o_text_length
);

    logic             r_vld  [0:DAB_STAGES];
    t_mode            r_mode [0:DAB_STAGES];
    logic             r_neg  [0:DAB_STAGES];
    logic [7:0]       r_byte [0:DAB_STAGES];
    logic [BIN_W-1:0] r_bin  [0:DAB_STAGES-1];
    logic [BCD_W-1:0] r_bcd  [1:DAB_STAGES];

    logic             n_accept;
    t_mode            n_mode;
    logic             n_neg;
    logic [BIN_W-1:0] n_mag;

    t_char            r_text [0:NUM_CHARS-1];
    t_char            n_text [0:NUM_CHARS-1];
    logic [3:0]       r_len;
    logic [3:0]       n_len;
    logic             r_strobe;

    assign o_busy   = 1'b0;
    assign n_accept = i_start && !o_busy;

    // entry: pick the operand for the format, take the magnitude for signed
    always_comb begin
        n_neg = 1'b0;
        case (i_format)
            FMT_HEX8: begin
                n_mode = MODE_HEX8;
                n_mag  = {24'd0, i_value[7:0]};
            end
            FMT_DEC8: begin
                n_mode = MODE_DEC8;
                n_mag  = {24'd0, i_value[7:0]};
            end
            FMT_DEC16: begin
                n_mode = MODE_DEC16;
                n_mag  = {16'd0, i_value[15:0]};
            end
            FMT_DEC32: begin
                n_mode = MODE_DEC32;
                n_mag  = i_value;
            end
            default: begin
                n_mode = MODE_SIGNED;
                n_neg  = i_value[BIN_W-1];
                n_mag  = n_neg ? (~i_value + 32'd1) : i_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= n_accept;
        end
        r_mode[0] <= n_mode;
        r_neg[0]  <= n_neg;
        r_byte[0] <= i_value[7:0];
        r_bin[0]  <= n_mag;
    end

    for (genvar s = 0; s < DAB_STAGES; s++) begin : g_dab
        logic [BCD_W-1:0] n_bcd;
        logic [BIN_W-1:0] n_bin;

        always_comb begin
            n_bcd = (s == 0) ? '0 : r_bcd[(s == 0) ? 1 : s];
            n_bin = r_bin[s];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                n_bcd = dabble(n_bcd, n_bin[BIN_W-1]);
                n_bin = {n_bin[BIN_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_mode[s+1] <= r_mode[s];
            r_neg[s+1]  <= r_neg[s];
            r_byte[s+1] <= r_byte[s];
            r_bcd[s+1]  <= n_bcd;
        end

        if (s < DAB_STAGES - 1) begin : g_bin
            always_ff @(posedge i_clk) begin
                r_bin[s+1] <= n_bin;
            end
        end
    end

    // formatting: digits are least significant first in the bcd word
    always_comb begin
        for (int c = 0; c < NUM_CHARS; c++) begin
            n_text[c] = '0;
        end
        case (r_mode[DAB_STAGES])
            MODE_HEX8: begin
                n_text[0] = hex_char(r_byte[DAB_STAGES][7:4]);
                n_text[1] = hex_char(r_byte[DAB_STAGES][3:0]);
                n_len     = LEN_HEX8;
            end
            MODE_DEC8: begin
                for (int c = 0; c < 3; c++) begin
                    n_text[c] = dec_char(r_bcd[DAB_STAGES][4*(2-c) +: 4]);
                end
                n_len = LEN_DEC8;
            end
            MODE_DEC16: begin
                for (int c = 0; c < 5; c++) begin
                    n_text[c] = dec_char(r_bcd[DAB_STAGES][4*(4-c) +: 4]);
                end
                n_len = LEN_DEC16;
            end
            MODE_DEC32: begin
                for (int c = 0; c < DIGITS; c++) begin
                    n_text[c] = dec_char(r_bcd[DAB_STAGES][4*(DIGITS-1-c) +: 4]);
                end
                n_len = LEN_DEC32;
            end
            default: begin
                n_text[0] = r_neg[DAB_STAGES] ? CH_MINUS : CH_PLUS;
                for (int c = 0; c < DIGITS; c++) begin
                    n_text[c+1] = dec_char(r_bcd[DAB_STAGES][4*(DIGITS-1-c) +: 4]);
                end
                n_len = LEN_SIGNED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[DAB_STAGES];
        end
        r_text <= n_text;
        r_len  <= n_len;
    end

    assign o_strobe      = r_strobe;
    assign o_text_0      = r_text[0];
    assign o_text_1      = r_text[1];
    assign o_text_2      = r_text[2];
    assign o_text_3      = r_text[3];
    assign o_text_4      = r_text[4];
    assign o_text_5      = r_text[5];
    assign o_text_6      = r_text[6];
    assign o_text_7      = r_text[7];
    assign o_text_8      = r_text[8];
    assign o_text_9      = r_text[9];
    assign o_text_10     = r_text[10];
    assign o_text_length = r_len;

endmodule

`default_nettype wire

/* verif/tb_binary_to_ascii_decimal_hex_top.sv */
`timescale 1ns / 1ps

module tb_binary_to_ascii_decimal_hex_top;
    import b2ad_pkg::*;

    localparam int LATENCY     = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 517;

    typedef struct packed {
        logic [10:0][7:0] text;
        logic [3:0]       length;
    } t_text_word;

    class t_ascii_text_checker;
        t_text_word pending_text[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function logic [7:0] hex_ascii(logic [3:0] nib);
            if (nib <= 4'd9) begin
                return CH_ZERO + 8'(nib);
            end
            return CH_UPPER + 8'(nib) - 8'd10;
        endfunction

        // ten decimal digits, least significant at index 0
        function logic [9:0][7:0] decimal_ascii(logic [31:0] x);
            logic [9:0][7:0] d;
            for (int i = 0; i < 10; i++) begin
                d[i] = CH_ZERO + 8'(x % 32'd10);
                x = x / 32'd10;
            end
            return d;
        endfunction

        function t_text_word format_text(logic [31:0] v, logic [2:0] f);
            t_text_word      t;
            logic [9:0][7:0] d;
            logic [31:0]     mag;
            t = '0;
            case (f)
                FMT_HEX8: begin
                    t.text[0] = hex_ascii(v[7:4]);
                    t.text[1] = hex_ascii(v[3:0]);
                    t.length  = LEN_HEX8;
                end
                FMT_DEC8: begin
                    d = decimal_ascii({24'd0, v[7:0]});
                    for (int i = 0; i < 3; i++) t.text[i] = d[2-i];
                    t.length = LEN_DEC8;
                end
                FMT_DEC16: begin
                    d = decimal_ascii({16'd0, v[15:0]});
                    for (int i = 0; i < 5; i++) t.text[i] = d[4-i];
                    t.length = LEN_DEC16;
                end
                FMT_DEC32: begin
                    d = decimal_ascii(v);
                    for (int i = 0; i < 10; i++) t.text[i] = d[9-i];
                    t.length = LEN_DEC32;
                end
                default: begin
                    // codes above four fall back to signed; the most negative word keeps 2^31
                    mag = v[31] ? (~v + 32'd1) : v;
                    d = decimal_ascii(mag);
                    t.text[0] = v[31] ? CH_MINUS : CH_PLUS;
                    for (int i = 0; i < 10; i++) t.text[i+1] = d[9-i];
                    t.length = LEN_SIGNED;
                end
            endcase
            return t;
        endfunction

        function void note_word(logic [31:0] v, logic [2:0] f);
            pending_text.push_back(format_text(v, f));
        endfunction

        function void check_word(t_text_word got);
            t_text_word want;
            if (pending_text.size() == 0) begin
                $error("result word with no expected text waiting");
                errors++;
                return;
            end
            want = pending_text.pop_front();
            for (int k = 0; k < 11; k++) begin
                if (got.text[k] !== want.text[k]) begin
                    $error("text_%0d: expected %h, actual %h", k, want.text[k], got.text[k]);
                    errors++;
                end
            end
            if (got.length !== want.length) begin
                $error("text_length: expected %0d, actual %0d", want.length, got.length);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_text.size();
        endfunction
    endclass

    logic        clk    = 1'b0;
    logic        rst_n  = 1'b0;
    logic        start  = 1'b0;
    logic [31:0] value  = '0;
    logic [2:0]  format = '0;
    logic        busy;
    logic        strobe;
    logic [7:0]  text_0, text_1, text_2, text_3, text_4, text_5;
    logic [7:0]  text_6, text_7, text_8, text_9, text_10;
    logic [3:0]  text_length;
    int          cycle_count = 0;

    t_ascii_text_checker sb = new();

    binary_to_ascii_decimal_hex_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_value       (value),
        .i_format      (format),
        .o_strobe      (strobe),
        .o_text_0      (text_0),
        .o_text_1      (text_1),
        .o_text_2      (text_2),
        .o_text_3      (text_3),
        .o_text_4      (text_4),
        .o_text_5      (text_5),
        .o_text_6      (text_6),
        .o_text_7      (text_7),
        .o_text_8      (text_8),
        .o_text_9      (text_9),
        .o_text_10     (text_10),
        .o_text_length (text_length)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        t_text_word got;
        cycle_count <= cycle_count + 1;
        if (rst_n && strobe) begin
            got.text = {text_10, text_9, text_8, text_7, text_6, text_5,
                        text_4, text_3, text_2, text_1, text_0};
            got.length = text_length;
            sb.check_word(got);
        end
        if (rst_n && start && !busy) begin
            sb.note_word(value, format);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [31:0] v, input logic [2:0] f, input int idle_pct);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            value  <= $urandom;
            format <= 3'($urandom);
            @(negedge clk);
        end
        start  <= 1'b1;
        value  <= v;
        format <= f;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.outstanding() > 0) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255);
            2: return $urandom_range(65535);
            3: begin
                repeat ($urandom_range(9)) p = p * 32'd10;
                p = p + 32'($urandom_range(2)) - 32'd1;
                return $urandom_range(1) ? -p : p;
            end
            4: return $urandom_range(1) ? 32'h8000_0000 + 32'($urandom_range(3))
                                        : 32'h7FFF_FFFF - 32'($urandom_range(3));
            default: return -32'($urandom_range(1000));
        endcase
    endfunction

    function automatic logic [2:0] pick_format();
        if ($urandom_range(9) < 8) begin
            return 3'($urandom_range(4));
        end
        return 3'($urandom_range(7, 5));
    endfunction

    initial begin
        int idle_pct;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int f = 0; f < 5; f++) begin
            send_word(32'h0000_0000, 3'(f), 0);
            send_word(32'hFFFF_FFFF, 3'(f), 0);
        end
        send_word(32'h8000_0000, FMT_DEC32 + 3'd1, 0);
        send_word(32'h7FFF_FFFF, FMT_DEC32 + 3'd1, 0);
        send_word(32'h7FFF_FFFF, FMT_DEC32, 0);
        send_word(32'h0000_00AB, FMT_HEX8, 0);
        send_word(32'h1234_5F9C, FMT_HEX8, 0);
        send_word(32'h0001_2345, FMT_DEC8, 0);
        send_word(32'hFFFE_FFFF, FMT_DEC16, 0);
        send_word(32'hFFFF_FFFE, 3'd5, 0);
        send_word(32'd12345, 3'd6, 0);
        send_word(32'h0000_0000, 3'd7, 0);
        send_word(32'd999_999_999, FMT_DEC32, 0);
        wait_drained();
        repeat (LATENCY + 2) @(negedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 27 : (phase == 1) ? 70 : 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(pick_value(), pick_format(), idle_pct);
            end
            wait_drained();
        end

        repeat (LATENCY + 5) @(negedge clk);
        if (sb.outstanding() > 0) begin
            $error("%0d expected words never arrived", sb.outstanding());
        end
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
